[rtl/mwr_pkg.sv]
// shared types and constants for the microwire eeprom word reader
`timescale 1ns / 1ps

package mwr_pkg;

   // default sequence geometry
   localparam int MWR_ADDR_BITS = 7;
   localparam int MWR_DATA_BITS = 16;

   // fixed payload field widths
   localparam int WORD_ADDR_W = 7;
   localparam int READ_WORD_W = 16;

   // read opcode sent ahead of the address: start bit and 10
   localparam logic [2:0] READ_OPCODE = 3'b110;

   // request kinds
   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   // request payload
   typedef struct packed {
      kind_type               kind;
      logic [WORD_ADDR_W-1:0] word_address;
      logic                   serial_in;
   } req_payload_type;

   // result payload
   typedef struct packed {
      logic                   chip_select;
      logic                   serial_clock;
      logic                   serial_out;
      logic                   busy_res;
      logic                   word_valid;
      logic [READ_WORD_W-1:0] read_word;
   } rsp_payload_type;

endpackage

[rtl/mwr_if.sv]
// valid/ready channel interfaces for request and result traffic
`timescale 1ns / 1ps

interface mwr_req_if
   import mwr_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mwr_rsp_if
   import mwr_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/mwr_core.sv]
// sequence state and per-request step logic of the word reader
`timescale 1ns / 1ps

module mwr_core
   import mwr_pkg::*;
#(
   parameter int ADDR_BITS = MWR_ADDR_BITS,
   parameter int DATA_BITS = MWR_DATA_BITS
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  req_payload_type item,
   output rsp_payload_type result
);

   localparam int CMD_BITS   = ADDR_BITS + 3;
   localparam int TOTAL_BITS = CMD_BITS + 1 + DATA_BITS;
   localparam int BP_W       = $clog2(TOTAL_BITS + 1);
   localparam logic [BP_W-1:0] FIRST_SAMPLE = BP_W'(CMD_BITS + 2);
   localparam logic [BP_W-1:0] LAST_PERIOD  = BP_W'(TOTAL_BITS);

   logic [BP_W-1:0]      bit_period_ff, bit_period_in;
   logic                 high_half_ff, high_half_in;
   logic                 in_progress_ff, in_progress_in;
   logic [CMD_BITS-1:0]  cmd_shift_ff, cmd_shift_in;
   logic [DATA_BITS-1:0] data_shift_ff, data_shift_in;

   logic [ADDR_BITS+WORD_ADDR_W-1:0] addr_wide;
   logic [ADDR_BITS-1:0]             addr;
   logic [DATA_BITS+READ_WORD_W-1:0] word_wide;

   // address masked or zero extended to the configured width
   assign addr_wide = {{ADDR_BITS{1'b0}}, item.word_address};
   assign addr      = addr_wide[ADDR_BITS-1:0];

   // next state and result for the request in hand
   always_comb begin
      bit_period_in  = bit_period_ff;
      high_half_in   = high_half_ff;
      in_progress_in = in_progress_ff;
      cmd_shift_in   = cmd_shift_ff;
      data_shift_in  = data_shift_ff;
      word_wide      = '0;
      result         = '0;

      case (item.kind)
         KIND_START: begin
            if (in_progress_ff) begin
               // start while busy: report held lines, nothing moves
               result.chip_select  = 1'b1;
               result.serial_clock = !high_half_ff && (bit_period_ff != '0);
               result.serial_out   = (bit_period_ff == '0 && !high_half_ff) ? 1'b0
                                     : cmd_shift_ff[CMD_BITS-1];
               result.busy_res     = 1'b1;
            end else begin
               in_progress_in      = 1'b1;
               bit_period_in       = '0;
               high_half_in        = 1'b0;
               cmd_shift_in        = {READ_OPCODE, addr};
               data_shift_in       = '0;
               result.chip_select  = 1'b1;
               result.busy_res     = 1'b1;
            end
         end
         KIND_TICK: begin
            if (!in_progress_ff) begin
               result = '0;
            end else if (high_half_ff) begin
               // clock high half of the current bit
               result.chip_select  = 1'b1;
               result.serial_clock = 1'b1;
               result.serial_out   = cmd_shift_ff[CMD_BITS-1];
               result.busy_res     = 1'b1;
               high_half_in        = 1'b0;
               bit_period_in       = bit_period_ff + BP_W'(1);
            end else begin
               // low half: sample the previous data bit first
               if (bit_period_ff >= FIRST_SAMPLE) begin
                  data_shift_in = {data_shift_ff[DATA_BITS-2:0], item.serial_in};
               end
               if (bit_period_ff >= LAST_PERIOD) begin
                  word_wide         = {{READ_WORD_W{1'b0}}, data_shift_in};
                  in_progress_in    = 1'b0;
                  bit_period_in     = '0;
                  high_half_in      = 1'b0;
                  cmd_shift_in      = '0;
                  result.word_valid = 1'b1;
                  result.read_word  = word_wide[READ_WORD_W-1:0];
               end else begin
                  if (bit_period_ff != '0) begin
                     cmd_shift_in = {cmd_shift_ff[CMD_BITS-2:0], 1'b0};
                  end
                  result.chip_select = 1'b1;
                  result.serial_out  = cmd_shift_in[CMD_BITS-1];
                  result.busy_res    = 1'b1;
                  high_half_in       = 1'b1;
               end
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // sequence state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff  <= '0;
         high_half_ff   <= 1'b0;
         in_progress_ff <= 1'b0;
         cmd_shift_ff   <= '0;
         data_shift_ff  <= '0;
      end else if (step_en) begin
         bit_period_ff  <= bit_period_in;
         high_half_ff   <= high_half_in;
         in_progress_ff <= in_progress_in;
         cmd_shift_ff   <= cmd_shift_in;
         data_shift_ff  <= data_shift_in;
      end
   end

endmodule

[rtl/microwire_eeprom_word_reader_top.sv]
// top level of the microwire eeprom word reader: request and result stages
//
//   channel   direction  payload
//   req_chan  in         kind, word_address, serial_in
//   rsp_chan  out        chip_select, serial_clock, serial_out, busy_res,
//                        word_valid, read_word
//
// one request per cycle sustained while results are taken; each request's result
// is offered after the input register, then the result register
// the combinational step logic between the two registers takes one request a cycle
// reset is synchronous and clears the sequence state and both stage valids
// a stalled result holds in its register while the input stage still fills;
// requests stop only when both stages are full
`timescale 1ns / 1ps

module microwire_eeprom_word_reader_top
   import mwr_pkg::*;
#(
   parameter int ADDR_BITS = MWR_ADDR_BITS,
   parameter int DATA_BITS = MWR_DATA_BITS
) (
   input logic        clock,
   input logic        reset,
   mwr_req_if.sink    req_chan,
   mwr_rsp_if.source  rsp_chan
);

   logic            in_vld_ff;
   req_payload_type in_data_ff;
   logic            out_vld_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type step_result;
   logic            advance;

   // stage handshakes
   assign advance        = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || advance;
   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.payload = out_data_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_data_ff <= req_chan.payload;
      end
   end

   // step logic and sequence state
   mwr_core #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .result  (step_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

endmodule

[tb/sv/mwr_word_read_checker.sv]
// line-level predictor and result checker for the microwire eeprom word reader
`timescale 1ns / 1ps

module mwr_word_read_checker
   import mwr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   mwr_req_if   req_mon,
   mwr_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   // sequence geometry at the default sizes
   localparam int CMD_BITS   = MWR_ADDR_BITS + 3;
   localparam int TOTAL_BITS = CMD_BITS + 1 + MWR_DATA_BITS;
   localparam int MAX_PRINTED = 40;

   // predicted sequencer state
   logic [4:0]               bit_index;
   logic                     high_half_next;
   logic                     reading;
   logic [CMD_BITS-1:0]      command_bits;
   logic [MWR_DATA_BITS-1:0] word_bits;

   // line levels still owed by the block, oldest first
   rsp_payload_type expected_line_levels[$];
   int              failures;

   // one line per mismatch, printing capped but every one counted
   task automatic report_mismatch(string what, longint got, longint want);
      failures++;
      if (failures <= MAX_PRINTED)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   // line levels driven for one request, advancing the predicted sequence
   function automatic rsp_payload_type advance_read_sequence(req_payload_type req);
      rsp_payload_type lv;
      lv = '0;
      if (req.kind == KIND_START) begin
         if (reading) begin
            // start while busy: hold the current lines, nothing moves
            lv.chip_select  = 1'b1;
            lv.serial_clock = !high_half_next && (bit_index != 0);
            lv.serial_out   = (bit_index == 0 && !high_half_next) ?
                              1'b0 : command_bits[CMD_BITS-1];
            lv.busy_res     = 1'b1;
         end else begin
            reading        = 1'b1;
            bit_index      = '0;
            high_half_next = 1'b0;
            command_bits   = {READ_OPCODE, req.word_address[MWR_ADDR_BITS-1:0]};
            word_bits      = '0;
            lv.chip_select = 1'b1;
            lv.busy_res    = 1'b1;
         end
      end else if (!reading) begin
         // tick while idle: all lines low
         lv = '0;
      end else if (high_half_next) begin
         // clock high half of the current bit
         lv.chip_select  = 1'b1;
         lv.serial_clock = 1'b1;
         lv.serial_out   = command_bits[CMD_BITS-1];
         lv.busy_res     = 1'b1;
         high_half_next  = 1'b0;
         bit_index       = bit_index + 5'd1;
      end else begin
         // low half: sample the previous data bit first
         if (bit_index >= CMD_BITS + 2)
            word_bits = {word_bits[MWR_DATA_BITS-2:0], req.serial_in};
         if (bit_index >= TOTAL_BITS) begin
            lv.word_valid  = 1'b1;
            lv.read_word   = word_bits;
            reading        = 1'b0;
            bit_index      = '0;
            high_half_next = 1'b0;
            command_bits   = '0;
         end else begin
            if (bit_index != 0)
               command_bits = command_bits << 1;
            lv.chip_select = 1'b1;
            lv.serial_out  = command_bits[CMD_BITS-1];
            lv.busy_res    = 1'b1;
            high_half_next = 1'b1;
         end
      end
      return lv;
   endfunction

   // compare one accepted result with the oldest expectation
   task automatic check_line_levels(rsp_payload_type got);
      rsp_payload_type want;
      if (expected_line_levels.size() == 0) begin
         report_mismatch("result with nothing expected", got, 0);
         return;
      end
      want = expected_line_levels.pop_front();
      if (got.chip_select !== want.chip_select)
         report_mismatch("chip_select", got.chip_select, want.chip_select);
      if (got.serial_clock !== want.serial_clock)
         report_mismatch("serial_clock", got.serial_clock, want.serial_clock);
      if (got.serial_out !== want.serial_out)
         report_mismatch("serial_out", got.serial_out, want.serial_out);
      if (got.busy_res !== want.busy_res)
         report_mismatch("busy_res", got.busy_res, want.busy_res);
      if (got.word_valid !== want.word_valid)
         report_mismatch("word_valid", got.word_valid, want.word_valid);
      if (got.read_word !== want.read_word)
         report_mismatch("read_word", got.read_word, want.read_word);
   endtask

   initial begin
      failures      = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   // watch both channels; results are retired before the new request is predicted
   always @(posedge clock) begin
      if (reset) begin
         bit_index      = '0;
         high_half_next = 1'b0;
         reading        = 1'b0;
         command_bits   = '0;
         word_bits      = '0;
         expected_line_levels.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            check_line_levels(rsp_mon.payload);
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            expected_line_levels.push_back(advance_read_sequence(req_mon.payload));
      end
      fail_count    <= failures;
      pending_count <= expected_line_levels.size();
   end

endmodule

[tb/sv/tb_microwire_eeprom_word_reader_top.sv]
// stimulus, flow control and verdict for the microwire eeprom word reader
`timescale 1ns / 1ps

module tb_microwire_eeprom_word_reader_top;
   import mwr_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int TICKS_PER_READ  = 2 * (MWR_ADDR_BITS + 3 + 1 + MWR_DATA_BITS) + 1;
   localparam int PHASE_REQUESTS  = 110;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 10;

   // data patterns for the serial input during a read
   typedef enum int {
      DATA_RANDOM,
      DATA_ZEROS,
      DATA_ONES
   } data_pattern_type;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic pressure_go;
   logic hold_off;
   int   cycle_count;
   int   phase_requests;
   int   reads_started;
   int   fail_count;
   int   pending_count;

   mwr_req_if req_chan ();
   mwr_rsp_if rsp_chan ();

   microwire_eeprom_word_reader_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mwr_word_read_checker line_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // clock generation
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result side ready with random stalls and a forced hold-off
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      hold_off = 1'b0;
      @(posedge clock);
      while (pressure_go !== 1'b1) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // offer one request, with a random gap first, and wait for acceptance
   task automatic send_request(kind_type kind, logic [WORD_ADDR_W-1:0] addr, logic sin);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= req_payload_type'{kind: kind, word_address: addr, serial_in: sin};
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   // one full word read with random content and some ignored noise around it
   task automatic run_word_read();
      logic [WORD_ADDR_W-1:0] addr;
      data_pattern_type       pattern;
      logic                   sin;
      int                     k;
      addr    = WORD_ADDR_W'($urandom_range(127));
      pattern = data_pattern_type'($urandom_range(9) < 2 ? $urandom_range(2) : DATA_RANDOM);
      if ($urandom_range(7) == 0) addr = '0;
      if ($urandom_range(7) == 0) addr = '1;
      if (reads_started == 0) begin
         addr    = '0;
         pattern = DATA_ZEROS;
      end else if (reads_started == 1) begin
         addr    = '1;
         pattern = DATA_ONES;
      end
      reads_started++;
      // noise ticks while idle
      if ($urandom_range(4) == 0) begin
         k = $urandom_range(1, 3);
         repeat (k) send_request(KIND_TICK, WORD_ADDR_W'($urandom), 1'($urandom));
      end
      send_request(KIND_START, addr, 1'($urandom));
      phase_requests++;
      for (int i = 0; i < TICKS_PER_READ; i++) begin
         // stray start while busy
         if ($urandom_range(24) == 0)
            send_request(KIND_START, WORD_ADDR_W'($urandom), 1'($urandom));
         case (pattern)
            DATA_ZEROS: sin = 1'b0;
            DATA_ONES:  sin = 1'b1;
            default:    sin = 1'($urandom);
         endcase
         send_request(KIND_TICK, WORD_ADDR_W'($urandom), sin);
         phase_requests++;
      end
   endtask

   // reset, directed requests, random phases, drain and verdict
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      pressure_go      = 1'b0;
      reads_started    = 0;
      phase_requests   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle ticks, start, starts while busy at each half
      send_request(KIND_TICK, '1, 1'b1);
      send_request(KIND_TICK, '0, 1'b0);
      send_request(KIND_START, '1, 1'b0);
      send_request(KIND_START, '0, 1'b1);
      send_request(KIND_TICK, '0, 1'b0);
      send_request(KIND_START, '0, 1'b0);
      send_request(KIND_TICK, '0, 1'b1);
      send_request(KIND_START, '1, 1'b1);
      send_request(KIND_TICK, '0, 1'b1);
      // finish that read with all ones, then one extra idle tick
      repeat (TICKS_PER_READ - 3) send_request(KIND_TICK, '0, 1'b1);
      send_request(KIND_TICK, '1, 1'b1);

      // random phases with different idling
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
               pressure_go    <= 1'b1;
            end
            1: begin
               send_idle_pct  <= 68;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct  <= 0;
               recv_stall_pct <= 68;
            end
            default: begin
               send_idle_pct  <= 35;
               recv_stall_pct <= 35;
            end
         endcase
         phase_requests = 0;
         while (phase_requests < PHASE_REQUESTS) run_word_read();
      end
      req_chan.valid <= 1'b0;

      // drain outstanding results
      recv_stall_pct <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[microwire_eeprom_word_reader_top.f]
rtl/mwr_pkg.sv
rtl/mwr_if.sv
rtl/mwr_core.sv
rtl/microwire_eeprom_word_reader_top.sv
tb/sv/mwr_word_read_checker.sv
tb/sv/tb_microwire_eeprom_word_reader_top.sv
